// ===== rtl/adi_pkg.sv =====
package adi_pkg;

   localparam int PIXEL_W  = 24;
   localparam int COORD_W  = 10;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   localparam logic [CSR_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

   localparam int MIN_WIDTH  = 3;
   localparam int MIN_HEIGHT = 4;
   localparam int GROUP_COLS = 3;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_LAST   = 2'd2;

   localparam int BEATS = 6;
   localparam logic [2:0] LAST_BEAT = 3'd5;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [GROUP_COLS-1:0] trio_type;

   typedef struct packed {
      trio_type three;
      trio_type two;
      trio_type one;
   } stack_type;

   typedef struct packed {
      stack_type           lines;
      trio_type            cur;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  r;
   } window_type;

   function automatic pixel_type avg_pix(pixel_type a, pixel_type b);
      logic [8:0] s_r;
      logic [8:0] s_g;
      logic [8:0] s_b;
      s_r = {1'b0, a[23:16]} + {1'b0, b[23:16]};
      s_g = {1'b0, a[15:8]} + {1'b0, b[15:8]};
      s_b = {1'b0, a[7:0]} + {1'b0, b[7:0]};
      return {s_r[8:1], s_g[8:1], s_b[8:1]};
   endfunction

   function automatic logic [7:0] green_avg(pixel_type a, pixel_type b);
      logic [8:0] s_g;
      s_g = {1'b0, a[15:8]} + {1'b0, b[15:8]};
      return s_g[8:1];
   endfunction

   function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== rtl/adi_req_if.sv =====
interface adi_req_if;
   logic                   valid;
   logic                   ready;
   adi_pkg::pixel_type     pixel;
   logic                   frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== rtl/adi_rsp_if.sv =====
interface adi_rsp_if;
   logic                          valid;
   logic                          ready;
   adi_pkg::pixel_type            out_pixel;
   logic [adi_pkg::COORD_W-1:0]   out_column;
   logic [adi_pkg::COORD_W-1:0]   out_row;
   logic                          last;

   modport source (output valid, output out_pixel, output out_column, output out_row,
                   output last, input ready);
   modport sink (input valid, input out_pixel, input out_column, input out_row,
                 input last, output ready);
endinterface

// ===== rtl/adi_csr_if.sv =====
interface adi_csr_if;
   logic                            valid;
   logic                            ready;
   logic [adi_pkg::CSR_IDX_W-1:0]   index;
   logic [adi_pkg::CSR_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/adi_lstore.sv =====
module adi_lstore #(
   parameter int DEPTH = 341,
   parameter int AW    = 9
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  adi_pkg::stack_type    wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output adi_pkg::stack_type    rd_data
);

   adi_pkg::stack_type mem [DEPTH];
   adi_pkg::stack_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/adi_score.sv =====
module adi_score (
   input  adi_pkg::window_type win,
   output logic                use_interp
);

   logic [7:0] a0;
   logic [7:0] a1;
   logic [7:0] a2;
   logic [7:0] a3;
   logic [8:0] d1;
   logic [8:0] d2;

   assign a0 = adi_pkg::green_avg(win.lines.three[0], win.lines.three[2]);
   assign a1 = adi_pkg::green_avg(win.lines.two[0], win.lines.two[2]);
   assign a2 = adi_pkg::green_avg(win.lines.one[0], win.lines.one[2]);
   assign a3 = adi_pkg::green_avg(win.cur[0], win.cur[2]);

   assign d1 = {1'b0, adi_pkg::abs_diff(a0, a2)} + {1'b0, adi_pkg::abs_diff(a1, a3)};
   assign d2 = {1'b0, adi_pkg::abs_diff(a0, a3)} + {1'b0, adi_pkg::abs_diff(a1, a2)};

   assign use_interp = d1 < d2;

endmodule

// ===== rtl/adi_emit.sv =====
module adi_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  adi_pkg::window_type   win,
   input  logic                  use_interp,
   output logic                  free,
   adi_rsp_if.source             rsp_bus
);

   adi_pkg::pixel_type                  pix_ff [adi_pkg::BEATS];
   adi_pkg::pixel_type                  pix_in [adi_pkg::BEATS];
   logic [adi_pkg::COORD_W-1:0]         x_ff;
   logic [adi_pkg::COORD_W-1:0]         r_ff;
   logic [2:0]                          beat_ff;
   logic [2:0]                          beat_in;
   logic                                valid_ff;
   logic                                valid_in;
   logic                                last_beat;

   always_comb begin
      for (int i = 0; i < adi_pkg::GROUP_COLS; i++) begin
         pix_in[2*i]   = win.lines.two[i];
         pix_in[2*i+1] = use_interp ? adi_pkg::avg_pix(win.lines.two[i], win.cur[i])
                                    : win.lines.one[i];
      end
   end

   assign last_beat = beat_ff == adi_pkg::LAST_BEAT;
   assign free      = !valid_ff || (rsp_bus.ready && last_beat);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = '0;
      end else if (valid_ff && rsp_bus.ready) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= pix_in;
         x_ff   <= win.x;
         r_ff   <= win.r;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.out_pixel  = pix_ff[beat_ff];
   assign rsp_bus.out_column = x_ff + adi_pkg::COORD_W'(beat_ff[2:1]);
   assign rsp_bus.out_row    = r_ff + adi_pkg::COORD_W'(beat_ff[0]);
   assign rsp_bus.last       = last_beat;

endmodule

// ===== rtl/block_adaptive_deinterlacer.sv =====
// Adaptive line-doubling deinterlacer. Pixels arrive in raster order, one per req_bus beat;
// frame_start on a beat puts it at row 0, column 0. Each three-column group of rows r..r+3
// (r even) yields six beats on rsp_bus once its last pixel arrives, ordered by column, upper
// row first, last set on the sixth. Trailing rows and columns outside full windows yield
// nothing. Rows are held in one line store of MAX_WIDTH/3 entries, each entry holding a
// column group of the three previous rows; it is read on the first pixel of a group and
// written back on the third, so pixels that yield nothing are taken every cycle unless an
// earlier window waits for the emitter. While a window holds the output port for six beats,
// pixels go on being taken if the capture register is free. A window is registered there,
// then in the emitter, before its first result. frame_width and frame_height are used
// saturated to [3, MAX_WIDTH] and [4, MAX_HEIGHT]; write them only while the block is idle.
module block_adaptive_deinterlacer #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic      clock,
   input  logic      reset,
   adi_req_if.sink   req_bus,
   adi_rsp_if.source rsp_bus,
   adi_csr_if.sink   csr_bus
);

   localparam int GROUPS = MAX_WIDTH / adi_pkg::GROUP_COLS;
   localparam int AW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int GW     = $clog2(GROUPS + 1);
   localparam int CW     = $clog2(MAX_WIDTH + 1);
   localparam int RW     = $clog2(MAX_HEIGHT + 1);
   localparam int EW     = (CW > adi_pkg::CSR_W) ? CW : adi_pkg::CSR_W;
   localparam int EH     = (RW > adi_pkg::CSR_W) ? RW : adi_pkg::CSR_W;

   logic [adi_pkg::CSR_W-1:0] width_ff;
   logic [adi_pkg::CSR_W-1:0] height_ff;
   logic [EW-1:0]             w_ext;
   logic [EW-1:0]             w_sat;
   logic [EH-1:0]             h_ext;
   logic [EH-1:0]             h_sat;
   logic [CW-1:0]             eff_w;
   logic [RW-1:0]             eff_h;

   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [1:0]    phase_ff;
   logic [1:0]    phase_in;
   logic [GW-1:0] grp_ff;
   logic [GW-1:0] grp_in;
   logic [CW-1:0] col_p;
   logic [RW-1:0] row_p;
   logic [1:0]    phase_p;
   logic [GW-1:0] grp_p;

   adi_pkg::pixel_type   held_ff [2];
   adi_pkg::stack_type   rd_data;
   adi_pkg::stack_type   wr_data;
   adi_pkg::trio_type    cur;
   adi_pkg::window_type  s1_ff;
   adi_pkg::window_type  s1_in;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;

   logic [CW-1:0]           x_full;
   logic [CW+9:0]           x_wide;
   logic [RW-1:0]           r_full;
   logic [RW+9:0]           r_wide;
   logic                    req_fire;
   logic                    emit_row;
   logic                    s1_load;
   logic                    emit_free;
   logic                    use_interp;
   logic                    rd_en;
   logic                    wr_en;

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= adi_pkg::FRAME_WIDTH_RESET;
         height_ff <= adi_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            adi_pkg::REG_FRAME_WIDTH: begin
               width_ff <= csr_bus.data;
            end
            adi_pkg::REG_FRAME_HEIGHT: begin
               height_ff <= csr_bus.data;
            end
            default: begin
            end
         endcase
      end
   end

   assign w_ext = EW'(width_ff);
   assign h_ext = EH'(height_ff);
   assign w_sat = (w_ext < EW'(adi_pkg::MIN_WIDTH)) ? EW'(adi_pkg::MIN_WIDTH) :
                  (w_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_ext;
   assign h_sat = (h_ext < EH'(adi_pkg::MIN_HEIGHT)) ? EH'(adi_pkg::MIN_HEIGHT) :
                  (h_ext > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : h_ext;
   assign eff_w = w_sat[CW-1:0];
   assign eff_h = h_sat[RW-1:0];

   // position tracking
   assign req_bus.ready = !s1_valid_ff || emit_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      col_p   = col_ff;
      row_p   = row_ff;
      phase_p = phase_ff;
      grp_p   = grp_ff;
      if (req_bus.frame_start) begin
         col_p   = '0;
         row_p   = '0;
         phase_p = adi_pkg::PHASE_FIRST;
         grp_p   = '0;
      end
      if (col_p >= eff_w) begin
         col_p   = '0;
         phase_p = adi_pkg::PHASE_FIRST;
         grp_p   = '0;
         row_p   = row_p + RW'(1);
      end
      if (row_p >= eff_h) begin
         row_p = '0;
      end

      col_in = col_p + CW'(1);
      row_in = row_p;
      if (phase_p == adi_pkg::PHASE_LAST) begin
         phase_in = adi_pkg::PHASE_FIRST;
         grp_in   = grp_p + GW'(1);
      end else begin
         phase_in = phase_p + 2'd1;
         grp_in   = grp_p;
      end
      if (col_in >= eff_w) begin
         col_in   = '0;
         phase_in = adi_pkg::PHASE_FIRST;
         grp_in   = '0;
         row_in   = row_p + RW'(1);
         if (row_in >= eff_h) begin
            row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         phase_ff <= adi_pkg::PHASE_FIRST;
         grp_ff   <= '0;
      end else if (req_fire) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
         grp_ff   <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && phase_p == adi_pkg::PHASE_FIRST) begin
         held_ff[0] <= req_bus.pixel;
      end
      if (req_fire && phase_p == adi_pkg::PHASE_SECOND) begin
         held_ff[1] <= req_bus.pixel;
      end
   end

   // line store access
   assign cur[0] = held_ff[0];
   assign cur[1] = held_ff[1];
   assign cur[2] = req_bus.pixel;

   assign rd_en = req_fire && phase_p == adi_pkg::PHASE_FIRST && grp_p < GW'(GROUPS);
   assign wr_en = req_fire && phase_p == adi_pkg::PHASE_LAST;

   assign wr_data.three = rd_data.two;
   assign wr_data.two   = rd_data.one;
   assign wr_data.one   = cur;

   adi_lstore #(
      .DEPTH (GROUPS),
      .AW    (AW)
   ) u_lstore (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (grp_p[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (grp_p[AW-1:0]),
      .rd_data (rd_data)
   );

   // window capture
   assign emit_row = row_p[0] && row_p >= RW'(3);
   assign s1_load  = wr_en && emit_row;

   assign x_full = col_p - CW'(2);
   assign r_full = row_p - RW'(3);
   assign x_wide = (CW+10)'(x_full);
   assign r_wide = (RW+10)'(r_full);

   always_comb begin
      s1_in.lines = rd_data;
      s1_in.cur   = cur;
      s1_in.x     = x_wide[adi_pkg::COORD_W-1:0];
      s1_in.r     = r_wide[adi_pkg::COORD_W-1:0];
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_valid_ff && emit_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
   end

   adi_score u_score (
      .win        (s1_ff),
      .use_interp (use_interp)
   );

   adi_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_valid_ff && emit_free),
      .win        (s1_ff),
      .use_interp (use_interp),
      .free       (emit_free),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== tb/deint_checker.sv =====
`timescale 1ns / 100ps

module deint_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  adi_pkg::pixel_type              req_pixel,
   input  logic                            req_frame_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  adi_pkg::pixel_type              rsp_pixel,
   input  logic [adi_pkg::COORD_W-1:0]     rsp_column,
   input  logic [adi_pkg::COORD_W-1:0]     rsp_row,
   input  logic                            rsp_last,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [adi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [adi_pkg::CSR_W-1:0]       csr_data,
   output int                              errors,
   output int                              pending,
   output int                              beats_checked,
   output int                              windows_blended
);

   localparam int LINE_MAX = 1024;
   localparam int ROW_MAX  = 1024;

   typedef struct packed {
      adi_pkg::pixel_type            pixel;
      logic [adi_pkg::COORD_W-1:0]   column;
      logic [adi_pkg::COORD_W-1:0]   row;
      logic                          last;
   } out_beat_type;

   out_beat_type window_beats[$];

   adi_pkg::pixel_type line_oldest [LINE_MAX];
   adi_pkg::pixel_type line_middle [LINE_MAX];
   adi_pkg::pixel_type line_newest [LINE_MAX];
   adi_pkg::pixel_type held_first;
   adi_pkg::pixel_type held_second;
   int unsigned col_pos;
   int unsigned row_pos;
   logic [adi_pkg::CSR_W-1:0] width_code;
   logic [adi_pkg::CSR_W-1:0] height_code;

   function automatic adi_pkg::pixel_type mean_rgb(adi_pkg::pixel_type p,
                                                   adi_pkg::pixel_type q);
      adi_pkg::pixel_type m;
      int k;
      for (k = 0; k < 3; k++) begin
         m[8*k +: 8] = 8'((int'(p[8*k +: 8]) + int'(q[8*k +: 8])) / 2);
      end
      return m;
   endfunction

   function automatic int green_gap(adi_pkg::pixel_type p, adi_pkg::pixel_type q);
      int gp;
      int gq;
      gp = int'(p[15:8]);
      gq = int'(q[15:8]);
      return (gp > gq) ? gp - gq : gq - gp;
   endfunction

   task automatic deinterlace_pixel(input adi_pkg::pixel_type pix, input logic restart);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned r;
      int i;
      int d_cross;
      int d_skip;
      bit blend;
      adi_pkg::pixel_type trio [3];
      adi_pkg::pixel_type a0, a1, a2, a3;
      adi_pkg::pixel_type top_row;
      adi_pkg::pixel_type low_row;
      w = (width_code < adi_pkg::MIN_WIDTH) ? adi_pkg::MIN_WIDTH :
          (width_code > LINE_MAX) ? LINE_MAX : width_code;
      h = (height_code < adi_pkg::MIN_HEIGHT) ? adi_pkg::MIN_HEIGHT :
          (height_code > ROW_MAX) ? ROW_MAX : height_code;
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;

      case (2'(col_pos % adi_pkg::GROUP_COLS))
         adi_pkg::PHASE_FIRST: held_first = pix;
         adi_pkg::PHASE_SECOND: held_second = pix;
         default: begin
            x = col_pos - 2;
            trio[0] = held_first;
            trio[1] = held_second;
            trio[2] = pix;
            if ((row_pos % 2) == 1 && row_pos >= 3) begin
               r = row_pos - 3;
               a0 = mean_rgb(line_oldest[x], line_oldest[x+2]);
               a1 = mean_rgb(line_middle[x], line_middle[x+2]);
               a2 = mean_rgb(line_newest[x], line_newest[x+2]);
               a3 = mean_rgb(trio[0], trio[2]);
               d_cross = green_gap(a0, a2) + green_gap(a1, a3);
               d_skip = green_gap(a0, a3) + green_gap(a1, a2);
               blend = (d_cross < d_skip);
               if (blend) windows_blended++;
               for (i = 0; i < 3; i++) begin
                  top_row = line_middle[x+i];
                  low_row = blend ? mean_rgb(top_row, trio[i]) : line_newest[x+i];
                  window_beats.push_back('{top_row, 10'(x + i), 10'(r), 1'b0});
                  window_beats.push_back('{low_row, 10'(x + i), 10'(r + 1), (i == 2)});
               end
            end
            for (i = 0; i < 3; i++) begin
               line_oldest[x+i] = line_middle[x+i];
               line_middle[x+i] = line_newest[x+i];
               line_newest[x+i] = trio[i];
            end
         end
      endcase

      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic check_field(input string what, input logic [23:0] want, input logic [23:0] got,
                              input out_beat_type ref_beat);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, beat for column %0d row %0d: expected %0h, actual %0h",
                  $time, what, ref_beat.column, ref_beat.row, want, got);
      end
   endtask

   always @(posedge clock) begin
      out_beat_type want;
      if (reset) begin
         width_code = adi_pkg::FRAME_WIDTH_RESET;
         height_code = adi_pkg::FRAME_HEIGHT_RESET;
         col_pos = 0;
         row_pos = 0;
         window_beats.delete();
         errors = 0;
         beats_checked = 0;
         windows_blended = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == adi_pkg::REG_FRAME_WIDTH) width_code = csr_data;
            else if (csr_index == adi_pkg::REG_FRAME_HEIGHT) height_code = csr_data;
         end
         if (req_valid && req_ready) deinterlace_pixel(req_pixel, req_frame_start);
         if (rsp_valid && rsp_ready) begin
            if (window_beats.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected beat: expected none, actual pixel %0h col %0d",
                        $time, rsp_pixel, rsp_column);
               $display("   row %0d last %0b", rsp_row, rsp_last);
            end else begin
               want = window_beats.pop_front();
               beats_checked++;
               check_field("pixel", want.pixel, rsp_pixel, want);
               check_field("column", want.column, rsp_column, want);
               check_field("row", want.row, rsp_row, want);
               check_field("last", want.last, rsp_last, want);
            end
         end
      end
      pending = window_beats.size();
   end

endmodule

// ===== tb/block_adaptive_deinterlacer_tb.sv =====
`timescale 1ns / 100ps

module block_adaptive_deinterlacer_tb;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int SETTLE      = 24;
   localparam int SQUEEZE     = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic squeeze_due = 1'b0;
   bit steady_feed;

   int errors;
   int pending;
   int beats_checked;
   int windows_blended;
   int pixels_sent;
   int geometries;
   int unsigned cycle_count;

   adi_pkg::pixel_type probe_pixels [24];

   adi_req_if req_bus ();
   adi_rsp_if rsp_bus ();
   adi_csr_if csr_bus ();

   always #6 clock = ~clock;

   block_adaptive_deinterlacer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   deint_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_pixel       (req_bus.pixel),
      .req_frame_start (req_bus.frame_start),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_pixel       (rsp_bus.out_pixel),
      .rsp_column      (rsp_bus.out_column),
      .rsp_row         (rsp_bus.out_row),
      .rsp_last        (rsp_bus.last),
      .csr_valid       (csr_bus.valid),
      .csr_ready       (csr_bus.ready),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .errors          (errors),
      .pending         (pending),
      .beats_checked   (beats_checked),
      .windows_blended (windows_blended)
   );

   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic adi_pkg::pixel_type random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return {8'($urandom), 8'($urandom_range(120, 136)), 8'($urandom)};
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input adi_pkg::pixel_type pix, input logic restart);
      int gap;
      gap = steady_feed ? 0 : idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= pix;
      req_bus.frame_start <= restart;
      do @(posedge clock); while (!req_bus.ready);
      pixels_sent++;
   endtask

   task automatic set_geometry(input logic [adi_pkg::CSR_W-1:0] width_code,
                               input logic [adi_pkg::CSR_W-1:0] height_code);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= adi_pkg::REG_FRAME_WIDTH;
      csr_bus.data <= width_code;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= adi_pkg::REG_FRAME_HEIGHT;
      csr_bus.data <= height_code;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      geometries++;
   endtask

   task automatic drain_results();
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_geometry(input logic [adi_pkg::CSR_W-1:0] width_code,
                               input logic [adi_pkg::CSR_W-1:0] height_code,
                               input int beats, input bit restarts);
      int i;
      drain_results();
      set_geometry(width_code, height_code);
      steady_feed = ($urandom_range(0, 2) == 0);
      for (i = 0; i < beats; i++) begin
         send_pixel(random_pixel(), i == 0 || (restarts && $urandom_range(0, 39) == 0));
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      wait (beats_checked >= 30);
      squeeze_due <= 1'b1;
   end

   initial begin
      int run_len;
      int k;
      bit squeezed;
      squeezed = 0;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (!squeezed && squeeze_due) begin
            squeezed = 1;
            rsp_bus.ready <= 1'b0;
            repeat (SQUEEZE) @(posedge clock);
         end
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 6);
         rsp_bus.ready <= 1'b1;
         k = 0;
         do begin
            @(posedge clock);
            k++;
         end while (k < run_len && !(squeeze_due && !squeezed));
         run_len = idle_cycles();
         if (run_len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (run_len) @(posedge clock);
         end
      end
   end

   initial begin
      int i;
      int g;
      int w;
      int h;
      logic [adi_pkg::CSR_W-1:0] w_code;
      logic [adi_pkg::CSR_W-1:0] h_code;

      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      req_bus.frame_start = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = adi_pkg::REG_FRAME_WIDTH;
      csr_bus.data = '0;
      pixels_sent = 0;
      geometries = 0;
      steady_feed = 0;

      // first frame: outer greens alternate dark and bright, blended lower line
      // second frame: tied scores, keep the direct lower line
      probe_pixels = '{24'h000000, 24'h123456, 24'h000000,
                       24'hFFFFFF, 24'h7F80FE, 24'hFFFFFF,
                       24'hFE00FE, 24'h00FF00, 24'hFE00FE,
                       24'h00FF01, 24'h80FF7F, 24'hFFFF00,
                       24'hFF1000, 24'h00FF00, 24'h0010FF,
                       24'h802001, 24'h7F7F7F, 24'h01207F,
                       24'hAA3055, 24'h55AA55, 24'h5530AA,
                       24'h0140FE, 24'hFE01FE, 24'hFF4001};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_geometry(11'd3, 11'd4);
      for (i = 0; i < 24; i++) begin
         send_pixel(probe_pixels[i], (i % 12) == 0);
      end
      req_bus.valid <= 1'b0;

      run_geometry(11'd48, 11'd1, 4 * 48 + 12, 1'b0);

      for (g = 0; g < 4; g++) begin
         w = $urandom_range(3, 9);
         h = $urandom_range(4, 6);
         w_code = (w == 3 && $urandom_range(0, 1) == 1) ? 11'($urandom_range(0, 2)) : 11'(w);
         h_code = (h == 4 && $urandom_range(0, 1) == 1) ? 11'($urandom_range(0, 3)) : 11'(h);
         run_geometry(w_code, h_code, w * h + $urandom_range(0, w * h / 2), 1'b1);
      end

      run_geometry(11'd0, 11'd2047, 3 * 14, 1'b0);

      drain_results();
      $display("Covered %0d pixels over %0d frame geometries, widths 3 to 48 and heights",
               pixels_sent, geometries);
      $display("clamped at both ends, with %0d beats checked and %0d blended windows.",
               beats_checked, windows_blended);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/adi_pkg.sv
rtl/adi_req_if.sv
rtl/adi_rsp_if.sv
rtl/adi_csr_if.sv
rtl/adi_lstore.sv
rtl/adi_score.sv
rtl/adi_emit.sv
rtl/block_adaptive_deinterlacer.sv
tb/deint_checker.sv
tb/block_adaptive_deinterlacer_tb.sv
